// File: sv/dphp_pkg.sv
package dphp_pkg;

  // Packet geometry
  localparam int DATA_CAPACITY      = 1024;
  localparam int NUMBER_TOKEN_CHARS = 11;
  localparam int HEADER_FIELDS      = 4;
  localparam int RADIX              = 10;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int ACC_W  = 32;
  localparam int LEN_W  = 11;
  localparam int STAT_W = 2;
  localparam int CNT_W  = $clog2(DATA_CAPACITY + 1);
  localparam int TCC_W  = $clog2(NUMBER_TOKEN_CHARS + 1);

  // Stream and register port widths
  localparam int OUT_BITS   = BYTE_W + STAT_W + ACC_W + BYTE_W + BYTE_W + ACC_W + LEN_W;
  localparam int TDATA_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int PAD_W      = TDATA_W - OUT_BITS;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd35;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

  // Register index, taken from paddr[2]
  localparam logic REG_DELIM = 1'b0;

  // Which token of the packet the parser is in
  typedef enum logic [2:0] {
    FLD_SEQ,
    FLD_FLAG,
    FLD_LAST,
    FLD_CSUM,
    FLD_DATA
  } field_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_SHORT    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_t;

  // One result beat
  typedef struct packed {
    logic                data_valid;
    logic [BYTE_W-1:0]   data_byte;
    logic                packet_done;
    status_t             status;
    logic [ACC_W-1:0]    seq_number;
    logic [BYTE_W-1:0]   flag_char;
    logic [BYTE_W-1:0]   last_char;
    logic [ACC_W-1:0]    checksum_value;
    logic [LEN_W-1:0]    data_length;
  } result_t;

  // Input beat handed from the input register to the parser
  typedef struct packed {
    logic              step;
    logic [BYTE_W-1:0] byte_value;
    logic              end_of_packet;
  } beat_t;

endpackage

// File: sv/dphp_cfg.sv
module dphp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dphp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dphp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dphp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [dphp_pkg::BYTE_W-1:0]      delimiter_char
);
  import dphp_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Delimiter register; writes to other addresses are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char <= DELIM_RESET;
    end else if (wr_en && paddr[2] == REG_DELIM) begin
      delimiter_char <= pwdata[BYTE_W-1:0];
    end
  end

  // Read back the delimiter, zero elsewhere.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DELIM) begin
      prdata = APB_DATA_W'(delimiter_char);
    end
  end

endmodule

// File: sv/dphp_parse.sv
module dphp_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  dphp_pkg::beat_t               beat,
  input  logic [dphp_pkg::BYTE_W-1:0]   delimiter_char,
  output logic                          emit,
  output dphp_pkg::result_t             result
);
  import dphp_pkg::*;

  field_t              field;
  field_t              field_next;
  logic [TCC_W-1:0]    tcc;
  logic [TCC_W-1:0]    tcc_next;
  logic                stopped;
  logic                stopped_next;
  logic [ACC_W-1:0]    seq_accum;
  logic [ACC_W-1:0]    seq_accum_next;
  logic [ACC_W-1:0]    csum_accum;
  logic [ACC_W-1:0]    csum_accum_next;
  logic [BYTE_W-1:0]   flag_hold;
  logic [BYTE_W-1:0]   flag_hold_next;
  logic [BYTE_W-1:0]   last_hold;
  logic [BYTE_W-1:0]   last_hold_next;
  logic [CNT_W-1:0]    payload_count;
  logic [CNT_W-1:0]    payload_count_next;
  logic                overflow;
  logic                overflow_next;

  logic                is_delim;
  logic                is_digit;
  logic [BYTE_W-1:0]   digit;
  logic [ACC_W-1:0]    num_base;
  logic [ACC_W-1:0]    num_value;
  logic                num_take;
  logic                kept;

  assign is_delim = (field != FLD_DATA) && (beat.byte_value == delimiter_char);
  assign is_digit = (beat.byte_value >= CHAR_ZERO) && (beat.byte_value <= CHAR_NINE);
  assign digit    = beat.byte_value - CHAR_ZERO;
  assign num_take = (tcc < TCC_W'(NUMBER_TOKEN_CHARS));

  // One decimal digit step on whichever number token is open.
  assign num_base  = (field == FLD_CSUM) ? csum_accum : seq_accum;
  assign num_value = num_base * ACC_W'(RADIX) + ACC_W'(digit[3:0]);

  // Token sequencing: a delimiter moves to the next token until the payload.
  always_comb begin
    field_next = field;
    if (is_delim) begin
      unique case (field)
        FLD_SEQ:  field_next = FLD_FLAG;
        FLD_FLAG: field_next = FLD_LAST;
        FLD_LAST: field_next = FLD_CSUM;
        FLD_CSUM: field_next = FLD_DATA;
        default:  field_next = FLD_DATA;
      endcase
    end
  end

  // Token contents and payload bookkeeping for this byte.
  always_comb begin
    tcc_next           = tcc;
    stopped_next       = stopped;
    seq_accum_next     = seq_accum;
    csum_accum_next    = csum_accum;
    flag_hold_next     = flag_hold;
    last_hold_next     = last_hold;
    payload_count_next = payload_count;
    overflow_next      = overflow;
    kept               = 1'b0;
    if (is_delim) begin
      tcc_next     = '0;
      stopped_next = 1'b0;
    end else begin
      unique case (field) inside
        FLD_SEQ, FLD_CSUM: begin
          if (num_take) begin
            tcc_next = tcc + 1'b1;
            if (!stopped) begin
              if (is_digit) begin
                if (field == FLD_SEQ) begin
                  seq_accum_next = num_value;
                end else begin
                  csum_accum_next = num_value;
                end
              end else begin
                stopped_next = 1'b1;
              end
            end
          end
        end
        FLD_FLAG, FLD_LAST: begin
          if (tcc == '0) begin
            if (field == FLD_FLAG) begin
              flag_hold_next = beat.byte_value;
            end else begin
              last_hold_next = beat.byte_value;
            end
            tcc_next = TCC_W'(1);
          end
        end
        default: begin
          if (payload_count < CNT_W'(DATA_CAPACITY)) begin
            payload_count_next = payload_count + 1'b1;
            kept               = 1'b1;
          end else begin
            overflow_next = 1'b1;
          end
        end
      endcase
    end
  end

  // Result beat: a kept payload byte, a packet report, or both.
  // The report looks at the token position after this byte, so a packet whose
  // final byte is the fourth delimiter is complete.
  always_comb begin
    result  = '0;
    emit    = kept || beat.end_of_packet;
    if (kept) begin
      result.data_valid = 1'b1;
      result.data_byte  = beat.byte_value;
    end
    if (beat.end_of_packet) begin
      result.packet_done = 1'b1;
      if (field_next != FLD_DATA) begin
        result.status = STAT_SHORT;
      end else begin
        result.status          = overflow_next ? STAT_OVERFLOW : STAT_OK;
        result.seq_number      = seq_accum_next;
        result.flag_char       = flag_hold_next;
        result.last_char       = last_hold_next;
        result.checksum_value  = csum_accum_next;
        result.data_length     = LEN_W'(payload_count_next);
      end
    end
  end

  // Parser state; the final byte of a packet clears it for the next one.
  always_ff @(posedge clk) begin
    if (rst || (beat.step && beat.end_of_packet)) begin
      field         <= FLD_SEQ;
      tcc           <= '0;
      stopped       <= 1'b0;
      seq_accum     <= '0;
      csum_accum    <= '0;
      flag_hold     <= '0;
      last_hold     <= '0;
      payload_count <= '0;
      overflow      <= 1'b0;
    end else if (beat.step) begin
      field         <= field_next;
      tcc           <= tcc_next;
      stopped       <= stopped_next;
      seq_accum     <= seq_accum_next;
      csum_accum    <= csum_accum_next;
      flag_hold     <= flag_hold_next;
      last_hold     <= last_hold_next;
      payload_count <= payload_count_next;
      overflow      <= overflow_next;
    end
  end

endmodule

// File: sv/delimited_packet_header_parser.sv
// Delimited packet header parser.
// The slave stream carries one packet byte per beat (tdata) with tlast on the
// final byte. The text seq#flag#last#checksum#data is split: the sequence and
// checksum tokens are read as decimal, flag and last keep their first byte,
// and every byte after the fourth delimiter leaves on the master stream as a
// payload beat (tuser set). The beat for a packet's final byte carries tlast
// and the header report: fields, kept payload length and status (ok, too few
// delimiters, or payload over capacity with the excess dropped).
// The delimiter byte is set through the APB port at address 0 (default '#').
// Throughput is one byte per cycle while the receiver keeps up: each byte is
// held in the input register, where the parser updates its state with a single
// multiply by ten, and a result appears on the master side on the next cycle.
// A byte that makes no result (header text, dropped overflow) is absorbed.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready then drops until the held beat is taken.
// Reset clears both registers and the parser and restores the delimiter.
module delimited_packet_header_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dphp_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] byte_value
  input  logic                             s_tlast,   // end_of_packet
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] data_byte, [9:8] status, [41:10] seq_number, [49:42] flag_char,
  // [57:50] last_char, [89:58] checksum_value, [100:90] data_length, rest zero
  output logic [dphp_pkg::TDATA_W-1:0]     m_tdata,
  output logic [0:0]                       m_tuser,   // [0] data_valid
  output logic                             m_tlast,   // packet_done
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dphp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dphp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dphp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import dphp_pkg::*;

  logic              in_vld;
  logic [BYTE_W-1:0] in_byte;
  logic              in_eop;
  logic              out_vld;
  result_t           out_res;
  logic [BYTE_W-1:0] delimiter_char;
  beat_t             beat;
  logic              emit;
  result_t           result;
  logic              out_free;
  logic              fire;

  dphp_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .delimiter_char (delimiter_char)
  );

  // The held byte is processed once its result, if any, has room.
  assign out_free = !out_vld || m_tready;
  assign fire     = in_vld && (!emit || out_free);
  assign s_tready = !in_vld || fire;

  assign beat.step          = fire;
  assign beat.byte_value    = in_byte;
  assign beat.end_of_packet = in_eop;

  dphp_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .beat           (beat),
    .delimiter_char (delimiter_char),
    .emit           (emit),
    .result         (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eop  <= s_tlast;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire && emit) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_res <= result;
    end
  end

  // Master side packing.
  assign m_tvalid = out_vld;
  assign m_tuser  = out_res.data_valid;
  assign m_tlast  = out_res.packet_done;
  assign m_tdata  = {{PAD_W{1'b0}}, out_res.data_length, out_res.checksum_value,
                     out_res.last_char, out_res.flag_char, out_res.seq_number,
                     out_res.status, out_res.data_byte};

endmodule

// File: sv/dphp_checker.sv
module dphp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [dphp_pkg::TDATA_W-1:0]  m_tdata,
  input logic [0:0]                    m_tuser,
  input logic                          m_tlast
);
  import dphp_pkg::*;

  // A stalled result beat keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // Every result beat is a payload byte, a packet report, or both.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[0] || m_tlast)
    else $error("result beat carries neither payload nor report");

  // Without a payload byte the data byte reads zero.
  a_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[BYTE_W-1:0] == '0)
    else $error("data byte set without payload");

  // Header report fields are zero except on the final beat of a packet,
  // and a short packet reports no header.
  a_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (!m_tlast || m_tdata[BYTE_W+STAT_W-1:BYTE_W] == STAT_SHORT)
      |-> m_tdata[OUT_BITS-1:BYTE_W+STAT_W] == '0)
    else $error("header report outside a full packet end");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind delimited_packet_header_parser dphp_checker u_dphp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: test/delimited_packet_header_parser_tb.sv
module delimited_packet_header_parser_tb;
  import dphp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES = 130;
  localparam int REPORT_MAX = 10;
  localparam logic [APB_ADDR_W-1:0] ADDR_DELIM = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

  // One received packet byte waiting to be sent.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              eop;
  } rx_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Bytes still to be sent, and parser outputs predicted but not yet seen.
  rx_byte_t          rx_bytes[$];
  result_t           parse_results[$];
  logic [BYTE_W-1:0] pkt_bytes[$];

  // Parser state mirrored by the predictor.
  logic [BYTE_W-1:0] delim = DELIM_RESET;
  field_t            fld = FLD_SEQ;
  int                tok_cnt = 0;
  logic              num_stop = 1'b0;
  logic [ACC_W-1:0]  seq_acc = '0;
  logic [ACC_W-1:0]  csum_acc = '0;
  logic [BYTE_W-1:0] flag_h = '0;
  logic [BYTE_W-1:0] last_h = '0;
  int                pay_cnt = 0;
  logic              ovf = 1'b0;

  bit  byte_taken = 1'b0;
  bit  send_steady = 1'b0;
  bit  recv_steady = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  mismatches = 0;
  int  cycles = 0;
  int  bytes_queued = 0;

  delimited_packet_header_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic report_diff(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("mismatch on %0s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // One character of a decimal token; only the first NUMBER_TOKEN_CHARS characters count.
  function automatic logic [ACC_W-1:0] digit_step(logic [ACC_W-1:0] acc,
                                                  logic [BYTE_W-1:0] b);
    if (tok_cnt < NUMBER_TOKEN_CHARS) begin
      tok_cnt++;
      if (!num_stop) begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          acc = acc * RADIX + (b - CHAR_ZERO);
        end else begin
          num_stop = 1'b1;
        end
      end
    end
    return acc;
  endfunction

  // Advance the parser by one byte and predict the output beat, if any.
  function automatic void parse_byte(input logic [BYTE_W-1:0] b, input logic eop,
                                     output logic has_beat, output result_t r);
    logic kept;
    kept = 1'b0;
    r = '0;
    if (fld != FLD_DATA && b == delim) begin
      fld = field_t'(fld + 3'd1);
      tok_cnt = 0;
      num_stop = 1'b0;
    end else if (fld == FLD_SEQ) begin
      seq_acc = digit_step(seq_acc, b);
    end else if (fld == FLD_CSUM) begin
      csum_acc = digit_step(csum_acc, b);
    end else if (fld == FLD_FLAG || fld == FLD_LAST) begin
      if (tok_cnt == 0) begin
        if (fld == FLD_FLAG) flag_h = b;
        else last_h = b;
        tok_cnt = 1;
      end
    end else if (pay_cnt < DATA_CAPACITY) begin
      pay_cnt++;
      kept = 1'b1;
      r.data_valid = 1'b1;
      r.data_byte = b;
    end else begin
      ovf = 1'b1;
    end

    // The final byte carries the header report and clears the parser.
    if (eop) begin
      r.packet_done = 1'b1;
      if (fld != FLD_DATA) begin
        r.status = STAT_SHORT;
      end else begin
        r.status = ovf ? STAT_OVERFLOW : STAT_OK;
        r.seq_number = seq_acc;
        r.flag_char = flag_h;
        r.last_char = last_h;
        r.checksum_value = csum_acc;
        r.data_length = pay_cnt[LEN_W-1:0];
      end
      fld = FLD_SEQ;
      tok_cnt = 0;
      num_stop = 1'b0;
      seq_acc = '0;
      csum_acc = '0;
      flag_h = '0;
      last_h = '0;
      pay_cnt = 0;
      ovf = 1'b0;
    end
    has_beat = eop || kept;
  endfunction

  // Input side: predict on every accepted beat. Output side: check every beat.
  always @(posedge clk) begin : watch
    result_t pred;
    result_t want;
    logic    has_beat;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        byte_taken = 1'b1;
        parse_byte(s_tdata, s_tlast, has_beat, pred);
        if (has_beat) parse_results.push_back(pred);
      end
      if (m_tvalid && m_tready) begin
        if (parse_results.size() == 0) begin
          report_diff("beat with nothing expected", '0, m_tdata[31:0]);
        end else begin
          want = parse_results.pop_front();
          if (m_tuser[0] !== want.data_valid)
            report_diff("data_valid", 32'(want.data_valid), 32'(m_tuser[0]));
          if (m_tdata[7:0] !== want.data_byte)
            report_diff("data_byte", 32'(want.data_byte), 32'(m_tdata[7:0]));
          if (m_tlast !== want.packet_done)
            report_diff("packet_done", 32'(want.packet_done), 32'(m_tlast));
          if (m_tdata[9:8] !== want.status)
            report_diff("status", 32'(want.status), 32'(m_tdata[9:8]));
          if (m_tdata[41:10] !== want.seq_number)
            report_diff("seq_number", want.seq_number, m_tdata[41:10]);
          if (m_tdata[49:42] !== want.flag_char)
            report_diff("flag_char", 32'(want.flag_char), 32'(m_tdata[49:42]));
          if (m_tdata[57:50] !== want.last_char)
            report_diff("last_char", 32'(want.last_char), 32'(m_tdata[57:50]));
          if (m_tdata[89:58] !== want.checksum_value)
            report_diff("checksum_value", want.checksum_value, m_tdata[89:58]);
          if (m_tdata[100:90] !== want.data_length)
            report_diff("data_length", 32'(want.data_length), 32'(m_tdata[100:90]));
          if (m_tdata[TDATA_W-1:OUT_BITS] !== '0)
            report_diff("tdata padding", '0, 32'(m_tdata[TDATA_W-1:OUT_BITS]));
        end
      end
    end
  end

  // Byte sender: next value is worked out first so each signal gets one update.
  always @(negedge clk) begin : send_side
    logic     next_valid;
    rx_byte_t next_byte;
    next_valid = s_tvalid;
    next_byte.value = s_tdata;
    next_byte.eop = s_tlast;
    if (byte_taken) begin
      next_valid = 1'b0;
      byte_taken = 1'b0;
    end
    if (!rst && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (rx_bytes.size() != 0) begin
        next_byte = rx_bytes.pop_front();
        next_valid = 1'b1;
        gap_left = send_steady ? 0 : pick_gap();
      end
    end
    s_tvalid <= next_valid;
    s_tdata <= next_byte.value;
    s_tlast <= next_byte.eop;
  end

  // Result receiver with random stalls.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_steady) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("delimited_packet_header_parser verification failed");
      $finish;
    end
  end

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    // Only the first register index exists; other writes are dropped.
    if (addr == ADDR_DELIM) delim = val[BYTE_W-1:0];
  endtask

  // Read the delimiter register back and compare with the mirrored value.
  task automatic check_delim();
    logic [APB_DATA_W-1:0] seen;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_DELIM;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    seen = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (seen[BYTE_W-1:0] !== delim) report_diff("delimiter readback", 32'(delim), seen);
  endtask

  // Hold off until every byte is sent and every predicted beat has come back.
  task automatic wait_idle();
    while (rx_bytes.size() != 0 || s_tvalid || parse_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Move the packet under construction to the send queue, tlast on its end.
  task automatic send_packet();
    rx_byte_t rb;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      rb.value = pkt_bytes[i];
      rb.eop = (i == pkt_bytes.size() - 1);
      rx_bytes.push_back(rb);
    end
    bytes_queued += pkt_bytes.size();
    pkt_bytes.delete();
  endtask

  task automatic add_string(string s);
    for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
  endtask

  function automatic logic [BYTE_W-1:0] rand_digit();
    logic [BYTE_W-1:0] b;
    do b = CHAR_ZERO + BYTE_W'($urandom_range(0, 9)); while (b == delim);
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_nondelim();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == delim);
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_nondigit();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255));
    while (b == delim || (b >= CHAR_ZERO && b <= CHAR_NINE));
    return b;
  endfunction

  // Decimal token: usually short, sometimes past the character limit,
  // now and then broken by a non-digit.
  task automatic add_number_token();
    int n;
    n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : $urandom_range(8, 14);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) pkt_bytes.push_back(rand_nondigit());
      else pkt_bytes.push_back(rand_digit());
    end
  endtask

  task automatic add_text_token();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) pkt_bytes.push_back(rand_nondelim());
  endtask

  task automatic add_header();
    add_number_token();
    pkt_bytes.push_back(delim);
    add_text_token();
    pkt_bytes.push_back(delim);
    add_text_token();
    pkt_bytes.push_back(delim);
    add_number_token();
    pkt_bytes.push_back(delim);
  endtask

  // Payload bytes are arbitrary; delimiters inside the payload are common.
  task automatic add_payload(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) pkt_bytes.push_back(delim);
      else pkt_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed packets, then truncated headers, then raw noise.
  task automatic random_packet();
    int kind;
    int k;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      add_header();
      add_payload(($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                                : $urandom_range(13, 40));
    end else if (kind < 88) begin
      k = $urandom_range(0, 3);
      add_number_token();
      if (k >= 1) begin
        pkt_bytes.push_back(delim);
        add_text_token();
      end
      if (k >= 2) begin
        pkt_bytes.push_back(delim);
        add_text_token();
      end
      if (k >= 3) begin
        pkt_bytes.push_back(delim);
        add_number_token();
      end
      if (pkt_bytes.size() == 0) pkt_bytes.push_back(rand_digit());
    end else begin
      k = $urandom_range(1, 16);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 3) == 0) pkt_bytes.push_back(delim);
        else pkt_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end
    end
    send_packet();
  endtask

  task automatic random_phase(logic [BYTE_W-1:0] new_delim, bit steady);
    int start;
    apb_write(ADDR_DELIM, {24'h0, new_delim});
    check_delim();
    send_steady = steady;
    recv_steady = steady;
    start = bytes_queued;
    while (bytes_queued - start < PHASE_BYTES) random_packet();
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    check_delim();

    // Directed packets with the default delimiter: payload extremes with the
    // final byte in the payload, a short header, and a sign, an empty token
    // and a leading blank in the header.
    add_string("7#Y#N#5#");
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'hFF);
    send_packet();
    add_string("1#2");
    send_packet();
    add_string("####");
    send_packet();
    add_string("-3##b# 9#");
    send_packet();
    wait_idle();

    // A write to an address with no register must leave the delimiter alone.
    apb_write(ADDR_UNUSED, $urandom());
    check_delim();

    random_phase(8'h00, 1'b1);
    random_phase(8'hFF, 1'b0);
    random_phase(BYTE_W'($urandom_range(0, 255)), 1'b0);
    random_phase(8'h2C, 1'b0);
    random_phase(DELIM_RESET, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("delimited_packet_header_parser verification clean");
    end else begin
      $display("delimited_packet_header_parser verification failed");
    end
    $finish;
  end

endmodule
